@@ hdl/fkud_pkg.sv @@
// Shared types, constants and datapath step functions for the f-k up/down wavefield splitter.
// Used by every module under hdl; depends on nothing else.
package fkud_pkg;

  localparam int BinW     = 12;
  localparam int CntW     = 13;
  localparam int SampW    = 32;
  localparam int ProdW    = 45;
  localparam int NumAW    = 51;
  localparam int RootW    = 31;
  localparam int RadW     = 62;
  localparam int QuoW     = 47;
  localparam int NDivA    = 51;
  localparam int NSqrt    = 31;
  localparam int NDivC    = 47;
  localparam int FifoDepth = 4;
  localparam int FifoAw   = 2;

  typedef enum logic [2:0] {
    REG_COUNT_X,
    REG_COUNT_T,
    REG_AXIS_RATIO,
    REG_SLOW_LIMIT,
    REG_INV_VEL_SQ
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_GATED,
    ST_ZERO_Q,
    ST_SAT
  } status_t;

  typedef struct packed {
    logic [CntW-1:0] count_x;
    logic [CntW-1:0] count_t;
    logic [31:0]     axis_ratio;
    logic [30:0]     slow_limit;
    logic [30:0]     inv_vel_sq;
  } cfg_t;

  typedef struct packed {
    logic                    vld;
    logic                    done;
    status_t                 status;
    logic signed [SampW-1:0] pr;
    logic signed [SampW-1:0] pi;
    logic signed [SampW-1:0] vr;
    logic signed [SampW-1:0] vi;
  } pl_t;

  typedef struct packed {
    pl_t              pl;
    logic [ProdW-1:0] prod;
    logic [CntW-1:0]  den;
  } fq_t;

  typedef struct packed {
    pl_t              pl;
    logic [CntW-1:0]  den;
    logic [CntW-1:0]  rem;
    logic [NumAW-1:0] num;
  } da_t;

  typedef struct packed {
    pl_t         pl;
    logic [61:0] psq;
  } sm_t;

  typedef struct packed {
    pl_t         pl;
    logic [30:0] rad;
  } sd_t;

  typedef struct packed {
    pl_t              pl;
    logic [32:0]      rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } sq_t;

  typedef struct packed {
    logic [30:0]     rem;
    logic [QuoW-1:0] num;
  } dcl_t;

  typedef struct packed {
    pl_t              pl;
    logic [RootW-1:0] q;
    dcl_t             re;
    dcl_t             im;
  } dc_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  function automatic da_t div_a_step(da_t s);
    logic [CntW:0] r2;
    da_t           o;
    o  = s;
    r2 = {s.rem, s.num[NumAW-1]};
    if (r2 >= {1'b0, s.den}) begin
      r2    = r2 - {1'b0, s.den};
      o.num = {s.num[NumAW-2:0], 1'b1};
    end else begin
      o.num = {s.num[NumAW-2:0], 1'b0};
    end
    o.rem = r2[CntW-1:0];
    return o;
  endfunction

  function automatic sq_t sqrt_step(sq_t s);
    logic [34:0] r;
    logic [34:0] trial;
    sq_t         o;
    o     = s;
    r     = {s.rem, s.rad[RadW-1:RadW-2]};
    trial = {2'b00, s.root, 2'b01};
    if (r >= trial) begin
      r      = r - trial;
      o.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      o.root = {s.root[RootW-2:0], 1'b0};
    end
    o.rem = r[32:0];
    o.rad = {s.rad[RadW-3:0], 2'b00};
    return o;
  endfunction

  function automatic dcl_t div_c_lane(dcl_t s, logic [RootW-1:0] q);
    logic [31:0] r2;
    dcl_t        o;
    o  = s;
    r2 = {s.rem, s.num[QuoW-1]};
    if (r2 >= {1'b0, q}) begin
      r2    = r2 - {1'b0, q};
      o.num = {s.num[QuoW-2:0], 1'b1};
    end else begin
      o.num = {s.num[QuoW-2:0], 1'b0};
    end
    o.rem = r2[30:0];
    return o;
  endfunction

  function automatic clamp_t clamp_out(logic signed [49:0] v);
    clamp_t o;
    if (v > 50'sh0_0000_7FFF_FFFF) begin
      o.val = 32'h7FFF_FFFF;
      o.sat = 1'b1;
    end else if (v < -50'sh0_0000_8000_0000) begin
      o.val = 32'h8000_0000;
      o.sat = 1'b1;
    end else begin
      o.val = v[31:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

endpackage

@@ hdl/fkud_cfg.sv @@
// Configuration register file of the f-k up/down wavefield splitter.
// Depends on fkud_pkg.
module fkud_cfg
  import fkud_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_x    <= 13'd256;
      cfg.count_t    <= 13'd1024;
      cfg.axis_ratio <= 32'd16777216;
      cfg.slow_limit <= 31'd708669603;
      cfg.inv_vel_sq <= 31'd477218588;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_COUNT_X:    cfg.count_x    <= cfg_data[CntW-1:0];
        REG_COUNT_T:    cfg.count_t    <= cfg_data[CntW-1:0];
        REG_AXIS_RATIO: cfg.axis_ratio <= cfg_data;
        REG_SLOW_LIMIT: cfg.slow_limit <= cfg_data[30:0];
        REG_INV_VEL_SQ: cfg.inv_vel_sq <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/fkud_front.sv @@
// Front end: accepts bins, checks the frame range and frequency half, and forms the
// slowness numerator and denominator. Depends on fkud_pkg.
module fkud_front
  import fkud_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,
  output logic         push,
  input  logic         full,
  output fq_t          item
);

  logic [BinW-1:0] x;
  logic [BinW-1:0] t;
  logic            out_of;
  logic [CntW-1:0] kmag;
  fq_t             item_next;

  assign x = s_tdata[11:0];
  assign t = s_tdata[23:12];

  always_comb begin
    out_of = ({1'b0, x} >= cfg.count_x) || ({1'b0, t} >= cfg.count_t) ||
             ({1'b0, t} < (cfg.count_t >> 1));
    if ({1'b0, x} < (cfg.count_x >> 1)) kmag = {1'b0, x};
    else kmag = cfg.count_x - {1'b0, x};
    item_next.pl.vld    = s_tvalid;
    item_next.pl.done   = out_of;
    item_next.pl.status = ST_GATED;
    item_next.pl.pr     = s_tdata[55:24];
    item_next.pl.pi     = s_tdata[87:56];
    item_next.pl.vr     = s_tdata[119:88];
    item_next.pl.vi     = s_tdata[151:120];
    item_next.prod      = {32'd0, kmag} * {13'd0, cfg.axis_ratio};
    item_next.den       = cfg.count_t - {1'b0, t};
  end

  assign push     = item.pl.vld && !full;
  assign s_tready = !item.pl.vld || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.pl.vld <= 1'b0;
    end else if (s_tready) begin
      item <= item_next;
    end
  end

endmodule

@@ hdl/fkud_fifo.sv @@
// Short queue between the front end and the arithmetic pipeline.
// Depends on fkud_pkg.
module fkud_fifo
  import fkud_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  fq_t  wr_item,
  output logic full,
  input  logic pop,
  output logic empty,
  output fq_t  rd_item
);

  fq_t             mem [FifoDepth];
  logic [FifoAw-1:0] wr_ptr;
  logic [FifoAw-1:0] rd_ptr;
  logic [FifoAw:0]   count;

  assign full    = (count == FifoAw'(0) + (FifoAw+1)'(FifoDepth));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ hdl/fkud_back.sv @@
// Arithmetic pipeline: slowness division, gate, vertical slowness square root,
// velocity division, sum and difference with clamping, output register. Depends on fkud_pkg.
module fkud_back
  import fkud_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         empty,
  input  fq_t          rd_item,
  output logic         pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,
  output logic [1:0]   m_tuser
);

  da_t a [NDivA];
  sm_t m;
  sd_t d;
  sq_t s [NSqrt];
  dc_t c [NDivC];

  logic en;
  da_t  a_in;
  logic gate;
  pl_t  m_pl_next;
  logic [32:0] diff;
  pl_t  d_pl_next;
  sq_t  s_in;
  dc_t  c_in;
  logic [31:0] abs_r;
  logic [31:0] abs_i;
  logic signed [48:0] qr;
  logic signed [48:0] qi;
  logic signed [49:0] pr50;
  logic signed [49:0] pi50;
  clamp_t u_r, u_i, d_r, d_i;
  logic [127:0] data_next;
  status_t      st_next;

  assign en  = !m_tvalid || m_tready;
  assign pop = en && !empty;

  always_comb begin
    a_in.pl     = rd_item.pl;
    a_in.pl.vld = !empty;
    a_in.den    = rd_item.den;
    a_in.rem    = '0;
    a_in.num    = {rd_item.prod, 6'd0};

    gate = !a[NDivA-1].pl.done && (a[NDivA-1].num >= {20'd0, cfg.slow_limit});
    m_pl_next = a[NDivA-1].pl;
    if (gate) begin
      m_pl_next.done   = 1'b1;
      m_pl_next.status = ST_GATED;
    end

    diff = {2'b00, cfg.inv_vel_sq} - {1'b0, m.psq[61:30]};
    d_pl_next = m.pl;
    if (!m.pl.done && (diff[32] || diff == '0)) begin
      d_pl_next.done   = 1'b1;
      d_pl_next.status = ST_ZERO_Q;
    end

    s_in.pl   = d.pl;
    s_in.rem  = '0;
    s_in.root = '0;
    s_in.rad  = {1'b0, d.rad, 30'd0};

    abs_r = s[NSqrt-1].pl.vr[31] ? (32'd0 - s[NSqrt-1].pl.vr) : s[NSqrt-1].pl.vr;
    abs_i = s[NSqrt-1].pl.vi[31] ? (32'd0 - s[NSqrt-1].pl.vi) : s[NSqrt-1].pl.vi;
    c_in.pl     = s[NSqrt-1].pl;
    c_in.q      = s[NSqrt-1].root;
    c_in.re.rem = {16'd0, abs_r[31:17]};
    c_in.re.num = {abs_r[16:0], 30'd0};
    c_in.im.rem = {16'd0, abs_i[31:17]};
    c_in.im.num = {abs_i[16:0], 30'd0};

    qr = c[NDivC-1].pl.vr[31] ? -$signed({2'b00, c[NDivC-1].re.num})
                               : $signed({2'b00, c[NDivC-1].re.num});
    qi = c[NDivC-1].pl.vi[31] ? -$signed({2'b00, c[NDivC-1].im.num})
                               : $signed({2'b00, c[NDivC-1].im.num});
    pr50 = 50'(c[NDivC-1].pl.pr);
    pi50 = 50'(c[NDivC-1].pl.pi);
    u_r = clamp_out(pr50 - 50'(qr));
    u_i = clamp_out(pi50 - 50'(qi));
    d_r = clamp_out(pr50 + 50'(qr));
    d_i = clamp_out(pi50 + 50'(qi));
    if (c[NDivC-1].pl.done) begin
      data_next = '0;
      st_next   = c[NDivC-1].pl.status;
    end else begin
      data_next = {d_i.val, d_r.val, u_i.val, u_r.val};
      st_next   = (u_r.sat || u_i.sat || d_r.sat || d_i.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NDivA; i++) a[i].pl.vld <= 1'b0;
      for (int i = 0; i < NSqrt; i++) s[i].pl.vld <= 1'b0;
      for (int i = 0; i < NDivC; i++) c[i].pl.vld <= 1'b0;
      m.pl.vld <= 1'b0;
      d.pl.vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      a[0] <= div_a_step(a_in);
      for (int i = 1; i < NDivA; i++) a[i] <= div_a_step(a[i-1]);

      m.pl  <= m_pl_next;
      m.psq <= {31'd0, a[NDivA-1].num[30:0]} * {31'd0, a[NDivA-1].num[30:0]};

      d.pl  <= d_pl_next;
      d.rad <= diff[30:0];

      s[0] <= sqrt_step(s_in);
      for (int i = 1; i < NSqrt; i++) s[i] <= sqrt_step(s[i-1]);

      c[0].pl <= c_in.pl;
      c[0].q  <= c_in.q;
      c[0].re <= div_c_lane(c_in.re, c_in.q);
      c[0].im <= div_c_lane(c_in.im, c_in.q);
      for (int i = 1; i < NDivC; i++) begin
        c[i].pl <= c[i-1].pl;
        c[i].q  <= c[i-1].q;
        c[i].re <= div_c_lane(c[i-1].re, c[i-1].q);
        c[i].im <= div_c_lane(c[i-1].im, c[i-1].q);
      end

      m_tvalid <= c[NDivC-1].pl.vld;
      m_tdata  <= data_next;
      m_tuser  <= st_next;
    end
  end

endmodule

@@ hdl/fk_updown_wavefield_split_core.sv @@
// Top level of the f-k up/down wavefield splitter.
// Depends on fkud_pkg, fkud_cfg, fkud_front, fkud_fifo and fkud_back.

// The block takes one frequency-wavenumber bin per cycle unless the output stalls, and
// returns one result per bin, in order. Each accepted item passes the front stage and the
// four-entry queue, then a pipeline whose length is set by its bit-serial units (51 stages
// of slowness division, one multiply, one compare, 31 square-root stages, 47 stages of
// velocity division and one output stage). Backpressure on the output stalls the whole
// pipeline; the queue and the front stage let the input take up to five more items
// meanwhile. Configuration registers should only be written while no bin is in flight.
module fk_updown_wavefield_split_core
  import fkud_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,  // x_bin, t_bin, pres_re, pres_im, vel_re, vel_im
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // up_re, up_im, down_re, down_im
  output logic [1:0]   m_tuser,  // bin_status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cfg_t cfg;
  fq_t  f_item;
  fq_t  q_item;
  logic push, full, pop, empty;

  fkud_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  fkud_front u_front (
    .clk, .rst, .cfg, .s_tvalid, .s_tready, .s_tdata, .push, .full, .item(f_item)
  );

  fkud_fifo u_fifo (
    .clk, .rst, .push, .wr_item(f_item), .full, .pop, .empty, .rd_item(q_item)
  );

  fkud_back u_back (
    .clk, .rst, .cfg, .empty, .rd_item(q_item), .pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the f-k up/down wavefield splitter core.
// Predicts every bin's up/down values and status in fixed point and compares results in order.
// Depends on fkud_pkg and fk_updown_wavefield_split_core.
`timescale 1ns / 1ps

module testbench
  import fkud_pkg::*;
;

  typedef struct {
    logic [31:0] up_re;
    logic [31:0] up_im;
    logic [31:0] down_re;
    logic [31:0] down_im;
    status_t     status;
  } split_t;

  class split_scoreboard;
    split_t pending[$];
    int     errors;
    logic [12:0] cnt_x;
    logic [12:0] cnt_t;
    logic [31:0] ratio;
    logic [30:0] limit;
    logic [30:0] slow_sq;

    function new();
      errors  = 0;
      cnt_x   = 13'd256;
      cnt_t   = 13'd1024;
      ratio   = 32'd16777216;
      limit   = 31'd708669603;
      slow_sq = 31'd477218588;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_COUNT_X:    cnt_x = val[12:0];
        REG_COUNT_T:    cnt_t = val[12:0];
        REG_AXIS_RATIO: ratio = val;
        REG_SLOW_LIMIT: limit = val[30:0];
        REG_INV_VEL_SQ: slow_sq = val[30:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic signed [63:0] scale_by_q(logic signed [31:0] s, logic [63:0] q);
      logic [63:0] a;
      logic [63:0] hi;
      logic [63:0] rm;
      logic [63:0] mag;
      a  = (s < 0) ? -64'(s) : 64'(s);
      hi = a / q;
      rm = a % q;
      if (hi >= (64'd1 << 32)) begin
        mag = 64'd1 << 62;
      end else begin
        mag = (hi << 30) + ((rm << 30) / q);
        if (mag > (64'd1 << 62)) mag = 64'd1 << 62;
      end
      return (s < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function logic [31:0] sat32(logic signed [63:0] v, ref bit sat);
      if (v > 64'sd2147483647) begin
        sat = 1;
        return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        sat = 1;
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    function void note_bin(logic [151:0] d);
      logic [11:0] x;
      logic [11:0] t;
      logic signed [31:0] pr, pi, vr, vi;
      logic [63:0] kmag, pmag, psq, q;
      logic signed [63:0] diff, qr, qi;
      bit sat;
      split_t e;
      x  = d[11:0];
      t  = d[23:12];
      pr = d[55:24];
      pi = d[87:56];
      vr = d[119:88];
      vi = d[151:120];
      sat = 0;
      e = '{0, 0, 0, 0, ST_GATED};
      if (x < cnt_x && t < cnt_t && t >= (cnt_t >> 1)) begin
        kmag = (x < (cnt_x >> 1)) ? 64'(x) : 64'(cnt_x - x);
        pmag = (kmag * 64'(ratio) * 64) / 64'(cnt_t - t);
        if (pmag < 64'(limit)) begin
          psq  = (pmag * pmag) >> 30;
          diff = $signed(64'(slow_sq)) - $signed(psq);
          q    = (diff > 0) ? int_sqrt(64'(diff) << 30) : 0;
          if (q == 0) begin
            e.status = ST_ZERO_Q;
          end else begin
            qr = scale_by_q(vr, q);
            qi = scale_by_q(vi, q);
            e.up_re   = sat32(64'(pr) - qr, sat);
            e.up_im   = sat32(64'(pi) - qi, sat);
            e.down_re = sat32(64'(pr) + qr, sat);
            e.down_im = sat32(64'(pi) + qi, sat);
            e.status  = sat ? ST_SAT : ST_OK;
          end
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [127:0] d, logic [1:0] st);
      split_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h status %0d", d, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.up_re) begin
        $error("up_re expected %h actual %h", e.up_re, d[31:0]);
        errors++;
      end
      if (d[63:32] !== e.up_im) begin
        $error("up_im expected %h actual %h", e.up_im, d[63:32]);
        errors++;
      end
      if (d[95:64] !== e.down_re) begin
        $error("down_re expected %h actual %h", e.down_re, d[95:64]);
        errors++;
      end
      if (d[127:96] !== e.down_im) begin
        $error("down_im expected %h actual %h", e.down_im, d[127:96]);
        errors++;
      end
      if (st !== e.status) begin
        $error("bin_status expected %0d actual %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  localparam int StallLimit = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  split_scoreboard sb;
  int idle_cycles = 0;
  bit stim_done;

  always #2 clk = ~clk;

  fk_updown_wavefield_split_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : sink_stalls
    int g;
    @(negedge rst);
    forever begin
      g = stim_done ? 0 : gap_len();
      m_tready <= (g == 0);
      repeat (g > 0 ? g : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_bin(logic [11:0] x, logic [11:0] t, logic [31:0] pr, logic [31:0] pi,
                          logic [31:0] vr, logic [31:0] vi);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {vi, vr, pi, pr, t, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_bin({vi, vr, pi, pr, t, x});
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly bins inside the decomposed half of the current frame, some anywhere.
  task automatic random_bins(int n);
    logic [11:0] x;
    logic [11:0] t;
    int cx, ct;
    cx = sb.cnt_x;
    ct = sb.cnt_t;
    repeat (n) begin
      if ($urandom_range(0, 9) < 8 && cx > 0 && ct > 1) begin
        x = $urandom_range(0, (cx > 4096 ? 4096 : cx) - 1);
        t = $urandom_range(ct / 2, (ct > 4096 ? 4096 : ct) - 1);
        if ($urandom_range(0, 3) == 0) x = (cx / 2 > 4) ? $urandom_range(0, 4) : x;
      end else begin
        x = $urandom;
        t = $urandom;
      end
      send_bin(x, t, rand_sample(), rand_sample(), rand_sample(), rand_sample());
    end
  endtask

  initial begin
    sb = new();
    stim_done = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset configuration.
    send_bin(0, 1023, 1000, -1000, 500, -500);
    send_bin(0, 100, 1, 1, 1, 1);
    send_bin(12'hFFF, 12'hFFF, 1, 1, 1, 1);
    send_bin(300, 600, 1, 1, 1, 1);
    send_bin(1, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(255, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_bin(128, 512, 7, -7, 3, -3);
    send_bin(1, 512, 12345, 678, -9999, 4321);
    send_bin(100, 1000, 5, 5, 5, 5);
    drain();
    // Zero vertical slowness: velocity term zero.
    write_reg(REG_INV_VEL_SQ, 0);
    send_bin(0, 1023, 9, 9, 9, 9);
    drain();
    // Small q gives saturation.
    write_reg(REG_INV_VEL_SQ, 1);
    send_bin(0, 1023, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(0, 1023, 3, -3, 1, -1);
    drain();
    write_reg(REG_COUNT_X, 0);
    write_reg(REG_COUNT_T, 0);
    send_bin(0, 0, 1, 1, 1, 1);
    drain();
    write_reg(REG_COUNT_X, 1);
    write_reg(REG_COUNT_T, 2);
    write_reg(REG_AXIS_RATIO, 32'hFFFF_FFFF);
    write_reg(REG_SLOW_LIMIT, 31'h7FFF_FFFF);
    write_reg(REG_INV_VEL_SQ, 31'h7FFF_FFFF);
    send_bin(0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
    send_bin(0, 0, 1, 1, 1, 1);
    send_bin(1, 1, 1, 1, 1, 1);
    drain();
    write_reg(REG_COUNT_X, 4096);
    write_reg(REG_COUNT_T, 4096);
    write_reg(REG_AXIS_RATIO, 0);
    write_reg(REG_SLOW_LIMIT, 0);
    send_bin(12'hFFF, 12'hFFF, 1, 1, 1, 1);
    drain();
    write_reg(REG_SLOW_LIMIT, 1);
    send_bin(12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
    send_bin(2048, 2048, 2, 2, 2, 2);
    drain();

    // Random phases through several settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_COUNT_X, 256);
          write_reg(REG_COUNT_T, 1024);
          write_reg(REG_AXIS_RATIO, 32'd16777216);
          write_reg(REG_SLOW_LIMIT, 31'd708669603);
          write_reg(REG_INV_VEL_SQ, 31'd477218588);
        end
        1: begin
          write_reg(REG_COUNT_X, $urandom_range(1, 64));
          write_reg(REG_COUNT_T, $urandom_range(2, 64));
          write_reg(REG_AXIS_RATIO, $urandom_range(1 << 18, 1 << 22));
        end
        2: begin
          write_reg(REG_COUNT_X, 4096);
          write_reg(REG_COUNT_T, 4096);
          write_reg(REG_AXIS_RATIO, $urandom);
          write_reg(REG_SLOW_LIMIT, $urandom_range(0, 31'h7FFF_FFFF));
        end
        3: begin
          write_reg(REG_COUNT_X, $urandom_range(1, 8191));
          write_reg(REG_COUNT_T, $urandom_range(0, 8191));
          write_reg(REG_AXIS_RATIO, $urandom_range(1 << 20, 1 << 26));
          write_reg(REG_SLOW_LIMIT, 31'h7FFF_FFFF);
          write_reg(REG_INV_VEL_SQ, $urandom_range(0, 31'h7FFF_FFFF));
        end
        4: begin
          write_reg(REG_COUNT_X, $urandom_range(2, 300));
          write_reg(REG_COUNT_T, $urandom_range(2, 300));
          write_reg(REG_INV_VEL_SQ, $urandom_range(0, 1 << 20));
        end
        default: begin
          write_reg(REG_COUNT_X, 4096);
          write_reg(REG_COUNT_T, 4096);
          write_reg(REG_AXIS_RATIO, $urandom_range(1 << 16, 1 << 24));
          write_reg(REG_SLOW_LIMIT, 31'd708669603);
          write_reg(REG_INV_VEL_SQ, 31'd477218588);
        end
      endcase
      random_bins(155);
      drain();
    end

    stim_done = 1;
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : watchdog
    wait (idle_cycles >= StallLimit);
    $display("testbench failed");
    $finish;
  end

endmodule
